/* design/ptpd_pkg.sv */
`default_nettype none
package ptpd_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int ELEM_W        = 32;
    localparam int PROD_W        = 64;
    localparam int SUM_W         = 64;
    localparam int MAG_W         = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = 3'd7;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t [3:0][3:0] matrix_t;

    typedef struct packed {
        logic [SUM_W-1:0] n_mag;
        logic             neg;
    } div_lane_t;
endpackage
`default_nettype wire

/* design/ptpd_if.sv */
`default_nettype none
interface ptpd_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ptpd_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               w_zero;
    logic               saturated;
    modport source (output valid, out_x, out_y, out_z, w_zero, saturated, input ready);
    modport sink (input valid, out_x, out_y, out_z, w_zero, saturated, output ready);
endinterface

interface ptpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/ptpd_regs.sv */
`default_nettype none
module ptpd_regs #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ptpd_cfg_if.sink              cfg,
    output ptpd_pkg::matrix_t     matrix
);
    import ptpd_pkg::*;

    localparam logic [CFG_DATA_W-1:0] ONE = CFG_DATA_W'(1) << FRAC_BITS;

    logic [NUM_REGS-1:0][CFG_DATA_W-1:0] regs_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_ROW0_C01] <= ONE << 32;
            regs_reg[REG_ROW0_C23] <= '0;
            regs_reg[REG_ROW1_C01] <= ONE;
            regs_reg[REG_ROW1_C23] <= '0;
            regs_reg[REG_ROW2_C01] <= '0;
            regs_reg[REG_ROW2_C23] <= ONE << 32;
            regs_reg[REG_ROW3_C01] <= '0;
            regs_reg[REG_ROW3_C23] <= ONE;
        end
        else if (cfg.valid)
        begin
            regs_reg[cfg.index] <= cfg.data;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            matrix[r][0] = regs_reg[2*r][63:32];
            matrix[r][1] = regs_reg[2*r][31:0];
            matrix[r][2] = regs_reg[2*r+1][63:32];
            matrix[r][3] = regs_reg[2*r+1][31:0];
        end
    end
endmodule
`default_nettype wire

/* design/ptpd_xform.sv */
`default_nettype none
// Stage 1: products; stage 2: column sums; stage 3: signs and magnitudes.
module ptpd_xform #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  wire logic signed [31:0]        px,
    input  wire logic signed [31:0]        py,
    input  wire logic signed [31:0]        pz,
    input  ptpd_pkg::matrix_t              matrix,
    output logic                           out_valid,
    output ptpd_pkg::div_lane_t [2:0]      lanes,
    output logic [ptpd_pkg::SUM_W-1:0]     d_mag,
    output logic                           w_zero
);
    import ptpd_pkg::*;

    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [PROD_W-1:0]      prod_reg [3][4];
    logic signed [PROD_W-1:0]      prod_next [3][4];
    logic signed [ELEM_W-1:0]      trans_reg [4];
    logic [SUM_W-1:0]              sum_reg [4];
    logic [SUM_W-1:0]              sum_next [4];
    div_lane_t [2:0]               lanes_reg, lanes_next;
    logic [SUM_W-1:0]              dmag_reg;
    logic                          wz_reg;
    logic signed [31:0]            pt [3];

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            for (int c = 0; c < 4; c++)
                prod_next[k][c] = (PROD_W'(pt[k]) * PROD_W'(matrix[k][c])) >>> FRAC_BITS;
        for (int c = 0; c < 4; c++)
            sum_next[c] = SUM_W'(prod_reg[0][c]) + SUM_W'(prod_reg[1][c])
                        + SUM_W'(prod_reg[2][c]) + SUM_W'(signed'(trans_reg[c]));
        for (int c = 0; c < 3; c++)
        begin
            lanes_next[c].neg   = sum_reg[c][SUM_W-1] ^ sum_reg[3][SUM_W-1];
            lanes_next[c].n_mag = sum_reg[c][SUM_W-1] ? (SUM_W'(0) - sum_reg[c]) : sum_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            for (int c = 0; c < 4; c++)
                trans_reg[c] <= matrix[3][c];
            sum_reg   <= sum_next;
            lanes_reg <= lanes_next;
            dmag_reg  <= sum_reg[3][SUM_W-1] ? (SUM_W'(0) - sum_reg[3]) : sum_reg[3];
            wz_reg    <= (sum_reg[3] == '0);
        end
    end

    assign out_valid = v3_reg;
    assign lanes     = lanes_reg;
    assign d_mag     = dmag_reg;
    assign w_zero    = wz_reg;
endmodule
`default_nettype wire

/* design/ptpd_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per stage.
module ptpd_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      adv,
    input  wire logic                      in_valid,
    input  ptpd_pkg::div_lane_t [2:0]      lanes,
    input  wire logic [ptpd_pkg::SUM_W-1:0] d_mag,
    input  wire logic                      w_zero,
    output logic                           out_valid,
    output logic signed [31:0]             qx,
    output logic signed [31:0]             qy,
    output logic signed [31:0]             qz,
    output logic                           out_w_zero,
    output logic                           out_sat
);
    import ptpd_pkg::*;

    localparam int STEPS = SUM_W + FRAC_BITS;
    localparam int REM_W = SUM_W + 1;
    localparam int Q_W   = 33;

    logic             v_reg    [STEPS+1];
    logic [SUM_W-1:0] n_reg    [STEPS+1][3];
    logic [REM_W-1:0] r_reg    [STEPS+1][3];
    logic [Q_W-1:0]   q_reg    [STEPS+1][3];
    logic             big_reg  [STEPS+1][3];
    logic             neg_reg  [STEPS+1][3];
    logic [SUM_W-1:0] d_reg    [STEPS+1];
    logic             wz_reg   [STEPS+1];
    logic [31:0]      res_reg  [3];
    logic             sat_reg, wzo_reg, vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= STEPS; s++)
                v_reg[s] <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= STEPS; s++)
                v_reg[s] <= v_reg[s-1];
            vo_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [REM_W-1:0] rt;
        logic [31:0]      mag;
        logic [31:0]      lim;
        logic             any_sat;
        logic             sat_c;
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                n_reg[0][c]   <= lanes[c].n_mag;
                r_reg[0][c]   <= '0;
                q_reg[0][c]   <= '0;
                big_reg[0][c] <= 1'b0;
                neg_reg[0][c] <= lanes[c].neg;
            end
            d_reg[0]  <= d_mag;
            wz_reg[0] <= w_zero;
            for (int s = 1; s <= STEPS; s++)
            begin
                d_reg[s]  <= d_reg[s-1];
                wz_reg[s] <= wz_reg[s-1];
                for (int c = 0; c < 3; c++)
                begin
                    rt = {r_reg[s-1][c][REM_W-2:0],
                          (s <= SUM_W) ? n_reg[s-1][c][SUM_W-s] : 1'b0};
                    n_reg[s][c]   <= n_reg[s-1][c];
                    neg_reg[s][c] <= neg_reg[s-1][c];
                    if (rt >= {1'b0, d_reg[s-1]})
                    begin
                        r_reg[s][c] <= rt - {1'b0, d_reg[s-1]};
                        q_reg[s][c] <= {q_reg[s-1][c][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[s][c] <= rt;
                        q_reg[s][c] <= {q_reg[s-1][c][Q_W-2:0], 1'b0};
                    end
                    big_reg[s][c] <= big_reg[s-1][c] | q_reg[s-1][c][Q_W-1];
                end
            end
            any_sat = 1'b0;
            for (int c = 0; c < 3; c++)
            begin
                lim   = neg_reg[STEPS][c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                sat_c = big_reg[STEPS][c] || q_reg[STEPS][c][Q_W-1]
                        || (q_reg[STEPS][c][31:0] > lim);
                mag   = sat_c ? lim : q_reg[STEPS][c][31:0];
                if (wz_reg[STEPS])
                    res_reg[c] <= '0;
                else
                    res_reg[c] <= neg_reg[STEPS][c] ? (32'd0 - mag) : mag;
                any_sat = any_sat | sat_c;
            end
            sat_reg <= any_sat & ~wz_reg[STEPS];
            wzo_reg <= wz_reg[STEPS];
        end
    end

    assign out_valid  = vo_reg;
    assign qx         = signed'(res_reg[0]);
    assign qy         = signed'(res_reg[1]);
    assign qz         = signed'(res_reg[2]);
    assign out_w_zero = wzo_reg;
    assign out_sat    = sat_reg;
endmodule
`default_nettype wire

/* design/point_transform_perspective_divide_top.sv */
`default_nettype none
// Transforms (x,y,z,1) by a 4x4 Q-format matrix and divides x, y, z by w.
// Fully pipelined: one point per cycle when not stalled, with a depth set mostly
// by the bit-per-stage divider. Stalls freeze the whole pipeline while the
// result is not taken. The user must write the matrix through cfg only while the
// pipe is empty (the block does not enforce this); reset loads the identity.
module point_transform_perspective_divide_top #(
    parameter int FRAC_BITS = ptpd_pkg::FRAC_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ptpd_point_if.sink   in_pt,
    ptpd_result_if.source out_res,
    ptpd_cfg_if.sink     cfg
);
    import ptpd_pkg::*;

    matrix_t           matrix;
    logic              adv;
    logic              xv, wz;
    div_lane_t [2:0]   lanes;
    logic [SUM_W-1:0]  dm;
    logic              dv;
    logic signed [31:0] qx, qy, qz;
    logic              qwz, qsat;

    assign adv         = out_res.ready | ~out_res.valid;
    assign in_pt.ready = adv;

    ptpd_regs #(.FRAC_BITS(FRAC_BITS)) u_regs (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .matrix(matrix)
    );

    ptpd_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_pt.valid),
        .px(in_pt.point_x), .py(in_pt.point_y), .pz(in_pt.point_z),
        .matrix(matrix), .out_valid(xv), .lanes(lanes), .d_mag(dm), .w_zero(wz)
    );

    ptpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(xv), .lanes(lanes),
        .d_mag(dm), .w_zero(wz), .out_valid(dv), .qx(qx), .qy(qy), .qz(qz),
        .out_w_zero(qwz), .out_sat(qsat)
    );

    assign out_res.valid     = dv;
    assign out_res.out_x     = qx;
    assign out_res.out_y     = qy;
    assign out_res.out_z     = qz;
    assign out_res.w_zero    = qwz;
    assign out_res.saturated = qsat;
endmodule
`default_nettype wire

/* verif/point_transform_perspective_divide_top_test.sv */
`default_nettype none
module point_transform_perspective_divide_top_test;
    import ptpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               w_zero;
        logic               saturated;
    } point_result_t;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int PIPE_DEPTH = 3 + 64 + FRAC + 2;
    localparam longint CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #6 clk = ~clk;

    ptpd_point_if  pt_bus ();
    ptpd_result_if res_bus ();
    ptpd_cfg_if    cfg_bus ();

    point_transform_perspective_divide_top uut (
        .clk(clk), .rst_n(rst_n), .in_pt(pt_bus.sink), .out_res(res_bus.source),
        .cfg(cfg_bus.sink)
    );

    logic [63:0] matrix_regs [NUM_REGS];
    point_result_t pending_results [$];
    int error_count = 0;
    int result_count = 0;
    int wzero_count = 0;
    int sat_count = 0;
    int ready_hold = 0;
    longint cycle_count = 0;
    bit idle_enable = 1'b1;

    function automatic logic signed [63:0] matrix_elem(int r, int c);
        logic [63:0] word;
        word = matrix_regs[r * 2 + c / 2];
        return (c % 2) ? $signed(word[31:0]) : $signed(word[63:32]);
    endfunction

    function automatic logic [63:0] floor_product(logic signed [63:0] a,
                                                  logic signed [63:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    function automatic logic [31:0] fixed_divide(logic [63:0] n, logic [63:0] d,
                                                 inout logic sat);
        logic nneg, dneg, neg;
        logic [63:0] nm, dm, q, r, mag, lim;
        nneg = n[63];
        dneg = d[63];
        neg = nneg ^ dneg;
        nm = nneg ? -n : n;
        dm = dneg ? -d : d;
        q = nm / dm;
        r = nm % dm;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if ((q >> (32 - FRAC)) != 0)
        begin
            mag = lim;
            sat = 1'b1;
        end
        else
        begin
            mag = q << FRAC;
            for (int i = FRAC - 1; i >= 0; i--)
            begin
                r = r << 1;
                if (r >= dm)
                begin
                    r = r - dm;
                    mag[i] = 1'b1;
                end
            end
            if (mag > lim)
            begin
                mag = lim;
                sat = 1'b1;
            end
        end
        mag = neg ? -mag : mag;
        return mag[31:0];
    endfunction

    function automatic point_result_t project_point(logic signed [31:0] px,
                                                    logic signed [31:0] py,
                                                    logic signed [31:0] pz);
        logic [63:0] sums [4];
        logic sat;
        point_result_t res;
        sat = 1'b0;
        for (int c = 0; c < 4; c++)
            sums[c] = floor_product(64'(px), matrix_elem(0, c))
                    + floor_product(64'(py), matrix_elem(1, c))
                    + floor_product(64'(pz), matrix_elem(2, c))
                    + matrix_elem(3, c);
        res = '0;
        if (sums[3] == 0)
        begin
            res.w_zero = 1'b1;
            return res;
        end
        res.x = fixed_divide(sums[0], sums[3], sat);
        res.y = fixed_divide(sums[1], sums[3], sat);
        res.z = fixed_divide(sums[2], sums[3], sat);
        res.saturated = sat;
        return res;
    endfunction

    task automatic random_gap();
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            pt_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        random_gap();
        pt_bus.valid <= 1'b1;
        pt_bus.point_x <= px;
        pt_bus.point_y <= py;
        pt_bus.point_z <= pz;
        @(posedge clk);
        while (!pt_bus.ready)
            @(posedge clk);
        pending_results.push_back(project_point(px, py, pz));
        @(negedge clk);
    endtask

    task automatic write_matrix_reg(logic [2:0] idx, logic [63:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        matrix_regs[idx] = value;
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        pt_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    function automatic logic [31:0] random_fixed();
        case ($urandom_range(0, 4))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            2: return 32'($signed($urandom_range(0, 32'h7F_FFFF)) - 32'sh40_0000);
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
            default: return 32'($signed($urandom_range(0, 32'hFFF_FFFF)) - 32'sh800_0000);
        endcase
    endfunction

    task automatic load_matrix(logic [63:0] values [NUM_REGS]);
        drain_pipeline();
        for (int i = 0; i < NUM_REGS; i++)
            write_matrix_reg(3'(i), values[i]);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic test_identity_extremes();
        logic [31:0] corners [6];
        corners = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                    32'hFFFF_FFFF, 32'hFFFF_0000};
        for (int i = 0; i < 6; i++)
            send_point(corners[i], corners[(i + 1) % 6], corners[(i + 3) % 6]);
    endtask

    task automatic test_zero_w_and_saturation();
        logic [63:0] m [NUM_REGS];
        m = '{{32'h0001_0000, 32'h0}, 64'h0, {32'h0, 32'h0001_0000}, 64'h0,
              64'h0, {32'h0001_0000, 32'h0000_0000}, 64'h0,
              {32'h0, 32'h0001_0000}};
        // w taken from y: y = 0 gives a zero w, tiny y saturates
        m[3] = {32'h0, 32'h0001_0000};
        m[7] = 64'h0;
        load_matrix(m);
        send_point(32'h0001_0000, 32'h0, 32'h0002_0000);
        send_point(32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        send_point(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h0003_0000, 32'h0002_0000, 32'hFFFD_0000);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        for (int i = 0; i < NUM_REGS; i++)
            m[i] = 64'hFFFF_FFFF_FFFF_FFFF;
        load_matrix(m);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
        for (int i = 0; i < NUM_REGS; i++)
            m[i] = (i % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000;
        load_matrix(m);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h0, 32'h1234_5678);
    endtask

    task automatic test_random_matrices();
        logic [63:0] m [NUM_REGS];
        for (int phase = 0; phase < 16; phase++)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                m[i] = {random_fixed(), random_fixed()};
            if (phase % 4 == 0)
                m[7][31:0] = 32'h0;
            if (phase >= 12)
                idle_enable = 1'b0;
            load_matrix(m);
            repeat (105)
                send_point(random_fixed(), random_fixed(), random_fixed());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no pending request");
                error_count++;
            end
            else
            begin
                point_result_t want;
                want = pending_results.pop_front();
                result_count++;
                if (want.w_zero) wzero_count++;
                if (want.saturated) sat_count++;
                if (res_bus.out_x !== want.x)
                begin
                    $error("out_x expected %h actual %h", want.x, res_bus.out_x);
                    error_count++;
                end
                if (res_bus.out_y !== want.y)
                begin
                    $error("out_y expected %h actual %h", want.y, res_bus.out_y);
                    error_count++;
                end
                if (res_bus.out_z !== want.z)
                begin
                    $error("out_z expected %h actual %h", want.z, res_bus.out_z);
                    error_count++;
                end
                if (res_bus.w_zero !== want.w_zero)
                begin
                    $error("w_zero expected %b actual %b", want.w_zero, res_bus.w_zero);
                    error_count++;
                end
                if (res_bus.saturated !== want.saturated)
                begin
                    $error("saturated expected %b actual %b", want.saturated,
                           res_bus.saturated);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            res_bus.ready <= 1'b0;
        end
        else if (!res_bus.ready || !idle_enable || $urandom_range(0, 5) != 0)
            res_bus.ready <= 1'b1;
        else
        begin
            ready_hold = $urandom_range(0, 2);
            res_bus.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        pt_bus.valid = 1'b0;
        pt_bus.point_x = '0;
        pt_bus.point_y = '0;
        pt_bus.point_z = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        res_bus.ready = 1'b0;
        matrix_regs = '{64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
                        64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000};
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_identity_extremes();
        test_zero_w_and_saturation();
        test_random_matrices();
        drain_pipeline();
        $display("Checked %0d points over 20 matrix settings", result_count);
        $display("Zero-w results: %0d, saturated results: %0d", wzero_count, sat_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
